FILE: rtl/gbte_pkg.sv
// ----------------------------------------------------------------------------
// gbte_pkg: shared types and constants for the gap buffer text engine
// Store geometry, operation and status codes, sequencer states and the
// control, flag and result structs passed between the engine's modules.
// ----------------------------------------------------------------------------
package gbte_pkg;

  // Store geometry
  localparam int unsigned CAPACITY = 4096;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned POS_W    = 13;
  localparam int unsigned CHAR_W   = 8;
  localparam int unsigned WRAP_W   = 8;

  localparam logic [CHAR_W-1:0] CHAR_NEWLINE = 8'h0A;
  localparam logic [CHAR_W-1:0] CHAR_NUL     = 8'h00;
  localparam logic [WRAP_W-1:0] WRAP_RESET   = 8'd80;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_READ   = 2'd2,
    OP_COUNT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_CLAMP = 2'd2,
    ST_NODEL = 2'd3
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SEEK,
    S_LEFT_RD,
    S_LEFT_WR,
    S_RIGHT_RD,
    S_RIGHT_WR,
    S_EDIT,
    S_RD_ISSUE,
    S_CNT_RD,
    S_CNT_PROC,
    S_FINISH
  } state_e;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic load;
    logic left_rd;
    logic left_wr;
    logic right_rd;
    logic right_wr;
    logic edit;
    logic rd_byte;
    logic cnt_rd;
    logic cnt_proc;
    logic finish;
  } ctrl_t;

  // Conditions from the datapath to the sequencer
  typedef struct packed {
    op_e  func;
    logic full;
    logic gap_above;
    logic gap_below;
    logic scan_end;
    logic scan_gap;
  } flags_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_out;
    logic [POS_W-1:0]  line_total;
    logic [POS_W-1:0]  text_length;
    logic [POS_W-1:0]  cursor;
    status_e           status;
  } result_t;

endpackage

FILE: rtl/gap_buffer_text_engine.sv
// ----------------------------------------------------------------------------
// gap_buffer_text_engine: text store with a movable gap
// Requests enter on in_valid_i / in_stall_o and carry func_i, position_i and
// char_in_i; one result per request leaves on out_valid_o / out_stall_i.
// The cfg channel (cfg_valid_i / cfg_ready_o / cfg_data_i) sets the wrap
// width; it is always ready. The user must write it only while no request
// is in flight; the block itself does not enforce this. One request is
// worked on at a time and in_stall_o is high meanwhile; the cost is set by
// the store, at most one byte access per step. A read reads one byte; an
// insert or delete moves the gap a byte at a time, a read and a write per
// byte, before the edit; a line count walks every byte of the text, and a
// refused insert goes straight to the result.
// The result waits in an output register; a new request is taken while it
// waits, and that request's result is held back until the register empties.
// Reset empties the text, puts the cursor at 0 and the wrap width at 80.
// The store contents are not cleared; only written bytes are ever read.
// ----------------------------------------------------------------------------
module gap_buffer_text_engine (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [1:0]                   func_i,
  input  logic [gbte_pkg::POS_W-1:0]   position_i,
  input  logic [gbte_pkg::CHAR_W-1:0]  char_in_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [gbte_pkg::CHAR_W-1:0]  char_out_o,
  output logic [gbte_pkg::POS_W-1:0]   line_total_o,
  output logic [gbte_pkg::POS_W-1:0]   text_length_o,
  output logic [gbte_pkg::POS_W-1:0]   cursor_o,
  output logic [1:0]                   status_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [gbte_pkg::WRAP_W-1:0]  cfg_data_i
);
  import gbte_pkg::*;

  ctrl_t   ctrl;
  flags_t  flags;
  result_t result;
  logic    busy;
  logic    out_free;
  logic    out_valid_q, out_valid_d;
  result_t out_q;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign out_free    = !out_valid_q || !out_stall_i;

  gbte_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (in_valid_i),
    .out_free_i  (out_free),
    .flags_i     (flags),
    .busy_o      (busy),
    .ctrl_o      (ctrl)
  );

  gbte_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (ctrl),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .func_i     (func_i),
    .position_i (position_i),
    .char_in_i  (char_in_i),
    .flags_o    (flags),
    .result_o   (result)
  );

  // Hold the result until the receiver takes it
  assign out_valid_d = ctrl.finish | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.finish) out_q <= result;
  end

  assign out_valid_o   = out_valid_q;
  assign char_out_o    = out_q.char_out;
  assign line_total_o  = out_q.line_total;
  assign text_length_o = out_q.text_length;
  assign cursor_o      = out_q.cursor;
  assign status_o      = out_q.status;

endmodule

FILE: rtl/gbte_seq.sv
// ----------------------------------------------------------------------------
// gbte_seq: operation sequencer
// Steps the datapath through gap moves, the edit, a byte read or the line
// count walk, at most one memory access per step, and hands over the result.
// ----------------------------------------------------------------------------
module gbte_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  input  logic            out_free_i,
  input  gbte_pkg::flags_t flags_i,
  output logic            busy_o,
  output gbte_pkg::ctrl_t ctrl_o
);
  import gbte_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (flags_i.func)
          OP_INSERT: state_d = flags_i.full ? S_FINISH : S_SEEK;
          OP_DELETE: state_d = S_SEEK;
          OP_READ:   state_d = S_RD_ISSUE;
          OP_COUNT:  state_d = S_CNT_RD;
          default:   state_d = S_FINISH;
        endcase
      end
      S_SEEK: begin
        if (flags_i.gap_above) begin
          state_d = S_LEFT_RD;
        end else if (flags_i.gap_below) begin
          state_d = S_RIGHT_RD;
        end else begin
          state_d = S_EDIT;
        end
      end
      S_LEFT_RD:  state_d = S_LEFT_WR;
      S_LEFT_WR:  state_d = S_SEEK;
      S_RIGHT_RD: state_d = S_RIGHT_WR;
      S_RIGHT_WR: state_d = S_SEEK;
      S_EDIT:     state_d = S_FINISH;
      S_RD_ISSUE: state_d = S_FINISH;
      S_CNT_RD: begin
        if (flags_i.scan_end) begin
          state_d = S_FINISH;
        end else if (!flags_i.scan_gap) begin
          state_d = S_CNT_PROC;
        end
      end
      S_CNT_PROC: state_d = S_CNT_RD;
      S_FINISH: begin
        if (out_free_i) state_d = S_IDLE;
      end
      default:    state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    ctrl_o   = '0;
    busy_o   = 1'b1;
    case (state_q)
      S_IDLE: begin
        busy_o       = 1'b0;
        ctrl_o.load  = req_valid_i;
      end
      S_LEFT_RD:  ctrl_o.left_rd  = 1'b1;
      S_LEFT_WR:  ctrl_o.left_wr  = 1'b1;
      S_RIGHT_RD: ctrl_o.right_rd = 1'b1;
      S_RIGHT_WR: ctrl_o.right_wr = 1'b1;
      S_EDIT:     ctrl_o.edit     = 1'b1;
      S_RD_ISSUE: ctrl_o.rd_byte  = 1'b1;
      S_CNT_RD:   ctrl_o.cnt_rd   = 1'b1;
      S_CNT_PROC: ctrl_o.cnt_proc = 1'b1;
      S_FINISH:   ctrl_o.finish   = out_free_i;
      default:    ctrl_o          = '0;
    endcase
  end

endmodule

FILE: rtl/gbte_dpath.sv
// ----------------------------------------------------------------------------
// gbte_dpath: gap buffer datapath
// Holds the text store, the gap bounds and the wrap width. One read port and
// one write port on the store, one gap pointer update and one line counter
// step per command from the sequencer.
// ----------------------------------------------------------------------------
module gbte_dpath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  gbte_pkg::ctrl_t              ctrl_i,
  input  logic                         cfg_we_i,
  input  logic [gbte_pkg::WRAP_W-1:0]  cfg_data_i,
  input  logic [1:0]                   func_i,
  input  logic [gbte_pkg::POS_W-1:0]   position_i,
  input  logic [gbte_pkg::CHAR_W-1:0]  char_in_i,
  output gbte_pkg::flags_t             flags_o,
  output gbte_pkg::result_t            result_o
);
  import gbte_pkg::*;

  logic [CHAR_W-1:0] mem [CAPACITY];

  logic [ADDR_W-1:0] gb_q, gb_d;
  logic [ADDR_W-1:0] gl_q, gl_d;
  logic [WRAP_W-1:0] wrap_q;
  op_e               func_q;
  logic [CHAR_W-1:0] char_q;
  logic [ADDR_W-1:0] target_q, target_d;
  status_e           status_q, status_d;
  logic              empty_q;
  logic [CHAR_W-1:0] rdata_q;
  logic [POS_W-1:0]  scan_q, scan_d;
  logic [WRAP_W-1:0] col_q, col_d;
  logic [POS_W-1:0]  lines_q, lines_d;

  logic [ADDR_W-1:0] len_w;
  logic              pos_big, pos_ge;
  logic [ADDR_W-1:0] rd_tgt, rd_phys;
  logic              rd_en, wr_en;
  logic [ADDR_W-1:0] rd_addr, wr_addr;
  logic [CHAR_W-1:0] wr_data;
  logic [WRAP_W:0]   col_inc;

  // Text length is the store size less the gap size
  assign len_w   = gb_q + ~gl_q;
  assign pos_big = position_i > POS_W'(len_w);
  assign pos_ge  = position_i >= POS_W'(len_w);
  assign rd_tgt  = pos_ge ? (len_w - ADDR_W'(1)) : position_i[ADDR_W-1:0];
  assign rd_phys = (rd_tgt < gb_q) ? rd_tgt : (rd_tgt + gl_q - gb_q + ADDR_W'(1));
  assign col_inc = {1'b0, col_q} + (WRAP_W+1)'(1);

  // Capture the request and set up the operation
  always_comb begin
    target_d = target_q;
    status_d = status_q;
    gb_d     = gb_q;
    gl_d     = gl_q;
    scan_d   = scan_q;
    col_d    = col_q;
    lines_d  = lines_q;
    if (ctrl_i.load) begin
      status_d = ST_OK;
      target_d = pos_big ? len_w : position_i[ADDR_W-1:0];
      scan_d   = '0;
      col_d    = '0;
      lines_d  = POS_W'(1);
      case (op_e'(func_i))
        OP_INSERT: begin
          if (gb_q == gl_q) begin
            status_d = ST_FULL;
          end else if (pos_big) begin
            status_d = ST_CLAMP;
          end
        end
        OP_DELETE: begin
          if (pos_big) status_d = ST_CLAMP;
        end
        OP_READ: begin
          target_d = rd_phys;
          if (pos_ge) status_d = ST_CLAMP;
        end
        default: status_d = ST_OK;
      endcase
    end
    // Shift one byte across the gap
    if (ctrl_i.left_wr) begin
      gb_d = gb_q - ADDR_W'(1);
      gl_d = gl_q - ADDR_W'(1);
    end
    if (ctrl_i.right_wr) begin
      gb_d = gb_q + ADDR_W'(1);
      gl_d = gl_q + ADDR_W'(1);
    end
    // Apply the edit at the gap
    if (ctrl_i.edit) begin
      if (func_q == OP_INSERT) begin
        gb_d = gb_q + ADDR_W'(1);
      end else if (gb_q != '0) begin
        gb_d = gb_q - ADDR_W'(1);
      end else begin
        status_d = ST_NODEL;
      end
    end
    // Walk the text, jumping over the gap
    if (ctrl_i.cnt_rd && !flags_o.scan_end) begin
      scan_d = flags_o.scan_gap ? (POS_W'(gl_q) + POS_W'(1)) : (scan_q + POS_W'(1));
    end
    // Count lines from the byte just read
    if (ctrl_i.cnt_proc) begin
      if (rdata_q == CHAR_NEWLINE) begin
        lines_d = lines_q + POS_W'(1);
        col_d   = '0;
      end else if (rdata_q != CHAR_NUL) begin
        if (col_inc >= {1'b0, wrap_q}) begin
          lines_d = lines_q + POS_W'(1);
          col_d   = '0;
        end else begin
          col_d   = col_inc[WRAP_W-1:0];
        end
      end
    end
  end

  // Memory port selection
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = scan_q[ADDR_W-1:0];
    wr_en   = 1'b0;
    wr_addr = gb_q;
    wr_data = rdata_q;
    if (ctrl_i.left_rd) begin
      rd_en   = 1'b1;
      rd_addr = gb_q - ADDR_W'(1);
    end
    if (ctrl_i.right_rd) begin
      rd_en   = 1'b1;
      rd_addr = gl_q + ADDR_W'(1);
    end
    if (ctrl_i.rd_byte) begin
      rd_en   = !empty_q;
      rd_addr = target_q;
    end
    if (ctrl_i.cnt_rd) begin
      rd_en   = !flags_o.scan_end && !flags_o.scan_gap;
    end
    if (ctrl_i.left_wr) begin
      wr_en   = 1'b1;
      wr_addr = gl_q;
    end
    if (ctrl_i.right_wr) begin
      wr_en   = 1'b1;
    end
    if (ctrl_i.edit && func_q == OP_INSERT) begin
      wr_en   = 1'b1;
      wr_data = char_q;
    end
  end

  // Text store
  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // Gap bounds and wrap width
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gb_q   <= '0;
      gl_q   <= ADDR_W'(CAPACITY - 1);
      wrap_q <= WRAP_RESET;
    end else begin
      gb_q <= gb_d;
      gl_q <= gl_d;
      if (cfg_we_i) wrap_q <= cfg_data_i;
    end
  end

  // Operation working registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      func_q  <= op_e'(func_i);
      char_q  <= char_in_i;
      empty_q <= (len_w == '0);
    end
    target_q <= target_d;
    status_q <= status_d;
    scan_q   <= scan_d;
    col_q    <= col_d;
    lines_q  <= lines_d;
  end

  // Conditions for the sequencer
  always_comb begin
    flags_o.func      = func_q;
    flags_o.full      = (status_q == ST_FULL);
    flags_o.gap_above = gb_q > target_q;
    flags_o.gap_below = gb_q < target_q;
    flags_o.scan_end  = (scan_q == POS_W'(CAPACITY));
    flags_o.scan_gap  = (scan_q >= POS_W'(gb_q)) && (scan_q <= POS_W'(gl_q));
  end

  // Result fields
  always_comb begin
    result_o.char_out    = (func_q == OP_READ && !empty_q) ? rdata_q : CHAR_NUL;
    result_o.line_total  = (func_q == OP_COUNT) ? lines_q : '0;
    result_o.text_length = POS_W'(len_w);
    result_o.cursor      = POS_W'(gb_q);
    result_o.status      = status_q;
  end

endmodule
